FILE: hw/rtl/pfbrm_pkg.sv
// Shared types and constants of the per-flow byte rate meter.
package pfbrm_pkg;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam logic [15:0] WINDOW_RESET = 16'd1000;

  // One slot's counters as kept in the slot memory.
  typedef struct packed {
    logic [7:0]  slot_type;
    logic [31:0] all_bytes;
    logic [31:0] second_bytes;
    logic [31:0] frame_bytes;
    logic [31:0] second_deadline;
    logic        deadline_armed;
    logic [4:0]  second_count;
    logic [4:0]  frame_count;
  } slot_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CLEAR  = 9'b000000010,
    ST_READ   = 9'b000000100,
    ST_SCAN   = 9'b000001000,
    ST_TICK   = 9'b000010000,
    ST_RECS   = 9'b000100000,
    ST_SUM    = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

endpackage

FILE: hw/rtl/per_flow_byte_rate_meter_unit.sv
// Per-flow byte rate meter: slot counters and record windows in block memories.
//
// Slot state lives in one memory of PLAYERS*TYPES entries and the two record windows in
// two memories of PLAYERS*TYPES*RECORDS entries, each with a registered read output.
// After reset a clearing pass writes every slot entry, one a cycle, while no transfer
// is accepted. An add reads the player's slots one per cycle until a free or matching
// one is found or none is left. A reset player writes TYPES entries. A query reads the
// slot, then each record, then runs two 48-step restoring divisions, one per mean; a
// query whose player or slot is out of range skips the records and divisions. A frame
// tick visits every slot and reads and rewrites the record windows of each occupied one.
// One transfer is in work at a time; the result waits in an output register while the
// next input is accepted, and a result that is not taken holds the next one back.
module per_flow_byte_rate_meter_unit #(
  parameter int PLAYERS = 16,
  parameter int TYPES   = 16,
  parameter int RECORDS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[1:0], player[5:2], slot[9:6], type_id[17:10], byte_count[33:18],
  // now_ms[65:34], zeros[71:66]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok[0], entry_valid[1], type_out[9:2], total_out[41:10], avg_second_out[73:42],
  // avg_frame_q8[113:74], zeros[119:114]
  output logic [119:0] m_tdata
);

  localparam int NSLOTS = PLAYERS * TYPES;
  localparam int SW = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int TW = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int RW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int NREC = NSLOTS * RECORDS;
  localparam int AW = (NREC > 1) ? $clog2(NREC) : 1;

  logic [15:0] window_ms;
  always_ff @(posedge clk) begin
    if (rst) window_ms <= pfbrm_pkg::WINDOW_RESET;
    else if (cfg_we) window_ms <= cfg_wdata;
  end

  // Memories.
  pfbrm_pkg::slot_t slot_mem [NSLOTS];
  logic [31:0] srec_mem [NREC];
  logic [31:0] frec_mem [NREC];
  logic [SW-1:0] s_raddr, s_waddr;
  logic s_we;
  pfbrm_pkg::slot_t s_wdata, s_rdata;
  logic [AW-1:0] r_raddr, r_waddr;
  logic sr_we, fr_we;
  logic [31:0] sr_wdata, fr_wdata, sr_rdata, fr_rdata;

  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_waddr] <= s_wdata;
    s_rdata <= slot_mem[s_raddr];
    if (sr_we) srec_mem[r_waddr] <= sr_wdata;
    if (fr_we) frec_mem[r_waddr] <= fr_wdata;
    sr_rdata <= srec_mem[r_raddr];
    fr_rdata <= frec_mem[r_raddr];
  end

  pfbrm_pkg::state_t state;
  logic [1:0]  mode;
  logic [3:0]  player, slot_in;
  logic [7:0]  type_id;
  logic [15:0] byte_count;
  logic [31:0] now_ms;
  logic [SW:0] idx;          // slot index, with a bit to mark the sweep end
  logic [TW:0] tcnt;         // slot within the player
  logic [RW:0] ridx;         // record position
  logic        rphase;       // record read issued, data arrives next cycle
  pfbrm_pkg::slot_t cur;
  logic        sec_close;
  logic [31:0] sec_prev, frm_prev;
  logic [39:0] sum_s, sum_f;
  logic [47:0] num;
  logic [47:0] rem;
  logic [5:0]  dstep;
  logic        div_sel;      // 0 second mean, 1 frame mean
  logic [4:0]  divisor;
  logic [39:0] quo;
  logic [31:0] avg_s;
  logic        res_ok, res_ev;
  logic [119:0] res_word;

  logic out_full;
  assign m_tvalid = out_full;
  assign s_tready = (state == pfbrm_pkg::ST_IDLE);
  wire accept = s_tvalid && s_tready;

  wire [SW-1:0] pbase = SW'(player) * SW'(TYPES);
  wire [SW-1:0] cur_idx = idx[SW-1:0];
  wire [AW-1:0] rec_base = AW'(cur_idx) * AW'(RECORDS);
  wire [31:0] tick_deadline = now_ms + 32'(window_ms);
  wire passed = !(now_ms - s_rdata.second_deadline >= 32'h8000_0000);

  // A frame tick always succeeds; the other modes check their player, type and slot.
  wire read_ok = (mode == pfbrm_pkg::MODE_TICK) ||
                 ((32'(player) < 32'(PLAYERS)) &&
                  !(mode == pfbrm_pkg::MODE_ADD && type_id == 8'd0) &&
                  !(mode == pfbrm_pkg::MODE_QUERY && 32'(slot_in) >= 32'(TYPES)));

  assign res_word = (mode == pfbrm_pkg::MODE_QUERY && res_ok) ?
                    {6'd0, quo, avg_s, cur.all_bytes, cur.slot_type, res_ev, 1'b1} :
                    {119'd0, res_ok};

  // Restoring divider step: the numerator shifts in from the top.
  wire [48:0] rem_sh = {rem, num[47]};
  wire        sub_ok = rem_sh >= 49'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfbrm_pkg::ST_CLEAR;
      idx <= '0;
      out_full <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != pfbrm_pkg::ST_OUT) out_full <= 1'b0;
      case (state)
        pfbrm_pkg::ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == (SW+1)'(NSLOTS - 1)) state <= pfbrm_pkg::ST_IDLE;
        end
        pfbrm_pkg::ST_IDLE: begin
          if (accept) begin
            mode <= s_tdata[1:0];
            player <= s_tdata[5:2];
            slot_in <= s_tdata[9:6];
            type_id <= s_tdata[17:10];
            byte_count <= s_tdata[33:18];
            now_ms <= s_tdata[65:34];
            tcnt <= '0;
            idx <= '0;
            ridx <= '0;
            rphase <= 1'b0;
            sum_s <= '0;
            sum_f <= '0;
            avg_s <= '0;
            quo <= '0;
            res_ev <= 1'b0;
            state <= pfbrm_pkg::ST_READ;
          end
        end
        pfbrm_pkg::ST_READ: begin
          // Decide per mode; reads are issued combinationally from idx, tcnt or slot_in.
          res_ok <= read_ok;
          if (mode == pfbrm_pkg::MODE_TICK) begin
            state <= pfbrm_pkg::ST_TICK;
          end else if (!read_ok) begin
            state <= pfbrm_pkg::ST_OUT;
          end else begin
            case (mode)
              pfbrm_pkg::MODE_ADD: begin
                tcnt <= tcnt + 1'b1;
                state <= pfbrm_pkg::ST_SCAN;
              end
              pfbrm_pkg::MODE_RESET: begin
                tcnt <= tcnt + 1'b1;
                if (tcnt == (TW+1)'(TYPES - 1)) state <= pfbrm_pkg::ST_OUT;
              end
              default: begin
                state <= pfbrm_pkg::ST_SCAN;
              end
            endcase
          end
        end
        pfbrm_pkg::ST_SCAN: begin
          if (mode == pfbrm_pkg::MODE_ADD) begin
            // s_rdata holds slot tcnt-1.
            if (s_rdata.slot_type == 8'd0 || s_rdata.slot_type == type_id) begin
              state <= pfbrm_pkg::ST_OUT;
            end else if (tcnt == (TW+1)'(TYPES)) begin
              res_ok <= 1'b0;
              state <= pfbrm_pkg::ST_OUT;
            end else begin
              tcnt <= tcnt + 1'b1;
            end
          end else begin
            cur <= s_rdata;
            res_ev <= s_rdata.slot_type != 8'd0;
            idx <= (SW+1)'(pbase + SW'(slot_in));
            state <= pfbrm_pkg::ST_RECS;
          end
        end
        pfbrm_pkg::ST_TICK: begin
          // s_rdata holds slot idx (read issued in the cycle before).
          if (!rphase) begin
            rphase <= 1'b1;
          end else begin
            rphase <= 1'b0;
            if (s_rdata.slot_type == 8'd0) begin
              if (idx == (SW+1)'(NSLOTS - 1)) state <= pfbrm_pkg::ST_OUT;
              idx <= idx + 1'b1;
            end else begin
              cur <= s_rdata;
              sec_close <= s_rdata.deadline_armed && passed;
              ridx <= '0;
              state <= pfbrm_pkg::ST_RECS;
            end
          end
        end
        pfbrm_pkg::ST_RECS: begin
          if (mode == pfbrm_pkg::MODE_QUERY) begin
            if (!rphase) begin
              rphase <= 1'b1;
            end else begin
              rphase <= 1'b0;
              if (5'(ridx) < cur.second_count) sum_s <= sum_s + 40'(sr_rdata);
              if (5'(ridx) < cur.frame_count) sum_f <= sum_f + 40'(fr_rdata);
              ridx <= ridx + 1'b1;
              if (ridx == (RW+1)'(RECORDS - 1)) state <= pfbrm_pkg::ST_SUM;
            end
          end else begin
            // Tick: shift the full windows down one place, or append.
            if (!rphase) begin
              rphase <= 1'b1;
            end else begin
              rphase <= 1'b0;
              ridx <= ridx + 1'b1;
              if (ridx == (RW+1)'(RECORDS - 1)) begin
                if (idx == (SW+1)'(NSLOTS - 1)) state <= pfbrm_pkg::ST_OUT;
                else state <= pfbrm_pkg::ST_TICK;
                idx <= idx + 1'b1;
              end
            end
          end
        end
        pfbrm_pkg::ST_SUM: begin
          div_sel <= 1'b0;
          divisor <= cur.second_count;
          num <= {8'd0, sum_s};
          rem <= '0;
          dstep <= '0;
          state <= pfbrm_pkg::ST_DIV;
        end
        pfbrm_pkg::ST_DIV: begin
          if (dstep == 6'd47) begin
            if (!div_sel) begin
              avg_s <= (divisor == 5'd0) ? 32'd0 : num[30:0] << 1 | 32'(sub_ok);
              div_sel <= 1'b1;
              divisor <= cur.frame_count;
              num <= {sum_f, 8'd0};
              rem <= '0;
              dstep <= '0;
            end else begin
              quo <= (divisor == 5'd0) ? 40'd0 : {num[38:0], sub_ok};
              state <= pfbrm_pkg::ST_OUT;
            end
          end else begin
            rem <= sub_ok ? 48'(rem_sh - 49'(divisor)) : rem_sh[47:0];
            num <= {num[46:0], sub_ok};
            dstep <= dstep + 1'b1;
          end
        end
        pfbrm_pkg::ST_OUT: begin
          if (!out_full || m_tready) begin
            out_full <= 1'b1;
            m_tdata <= res_word;
            state <= pfbrm_pkg::ST_IDLE;
          end
        end
        default: state <= pfbrm_pkg::ST_IDLE;
      endcase
    end
  end

  // Memory address and write control.
  wire [SW-1:0] add_slot = pbase + SW'(tcnt - 1'b1);
  always_comb begin
    s_we = 1'b0;
    s_waddr = cur_idx;
    s_wdata = '0;
    s_raddr = cur_idx;
    r_raddr = rec_base + AW'(ridx);
    r_waddr = rec_base + AW'(ridx);
    sr_we = 1'b0;
    fr_we = 1'b0;
    sr_wdata = sr_rdata;
    fr_wdata = fr_rdata;
    sec_prev = '0;
    frm_prev = '0;
    case (state)
      pfbrm_pkg::ST_CLEAR: begin
        s_we = 1'b1;
      end
      pfbrm_pkg::ST_READ: begin
        s_raddr = (mode == pfbrm_pkg::MODE_QUERY) ? pbase + SW'(slot_in) : pbase + SW'(tcnt);
        if (mode == pfbrm_pkg::MODE_RESET && 32'(player) < 32'(PLAYERS)) begin
          s_we = 1'b1;
          s_waddr = pbase + SW'(tcnt);
        end
      end
      pfbrm_pkg::ST_SCAN: begin
        s_raddr = pbase + SW'(tcnt);
        if (mode == pfbrm_pkg::MODE_ADD &&
            (s_rdata.slot_type == 8'd0 || s_rdata.slot_type == type_id)) begin
          s_we = 1'b1;
          s_waddr = add_slot;
          s_wdata = s_rdata;
          s_wdata.slot_type = type_id;
          s_wdata.all_bytes = s_rdata.all_bytes + 32'(byte_count);
          s_wdata.second_bytes = s_rdata.second_bytes + 32'(byte_count);
          s_wdata.frame_bytes = s_rdata.frame_bytes + 32'(byte_count);
        end else if (mode == pfbrm_pkg::MODE_QUERY) begin
          r_raddr = AW'(pbase + SW'(slot_in)) * AW'(RECORDS);
        end
      end
      pfbrm_pkg::ST_TICK: begin
        r_raddr = rec_base;
        if (rphase && s_rdata.slot_type != 8'd0) begin
          s_we = 1'b1;
          s_wdata = s_rdata;
          s_wdata.frame_bytes = '0;
          s_wdata.frame_count = (s_rdata.frame_count >= 5'(RECORDS)) ?
                                5'(RECORDS) : s_rdata.frame_count + 5'd1;
          if (!s_rdata.deadline_armed) begin
            s_wdata.second_deadline = tick_deadline;
            s_wdata.deadline_armed = 1'b1;
          end else if (passed) begin
            s_wdata.second_bytes = '0;
            s_wdata.second_deadline = tick_deadline;
            s_wdata.second_count = (s_rdata.second_count >= 5'(RECORDS)) ?
                                   5'(RECORDS) : s_rdata.second_count + 5'd1;
          end
        end
      end
      pfbrm_pkg::ST_RECS: begin
        if (mode != pfbrm_pkg::MODE_QUERY) begin
          // Read position ridx+1 so that a full window shifts down by one.
          r_raddr = rec_base + AW'(ridx + 1'b1);
          if (rphase) begin
            sec_prev = (cur.second_count >= 5'(RECORDS)) ? sr_rdata : cur.second_bytes;
            frm_prev = (cur.frame_count >= 5'(RECORDS)) ? fr_rdata : cur.frame_bytes;
            if (ridx == (RW+1)'(RECORDS - 1)) begin
              sec_prev = cur.second_bytes;
              frm_prev = cur.frame_bytes;
            end
            sr_wdata = sec_prev;
            fr_wdata = frm_prev;
            // Full window: every position gets its successor, the last the new value.
            // Not full: only the position at the count gets the new value.
            sr_we = sec_close && ((cur.second_count >= 5'(RECORDS)) ||
                                  5'(ridx) == cur.second_count);
            fr_we = (cur.frame_count >= 5'(RECORDS)) || 5'(ridx) == cur.frame_count;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata));
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid);
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == pfbrm_pkg::ST_READ)
    else $error("accepted transfer did not start");
  assert property (@(posedge clk) disable iff (rst)
    s_we |-> (state != pfbrm_pkg::ST_IDLE))
    else $error("slot write while idle");

endmodule

FILE: sim/per_flow_byte_rate_meter_unit_tb.sv
// Testbench of the per-flow byte rate meter, checked against a slot-table predictor.
`timescale 1ns / 1ps

module per_flow_byte_rate_meter_unit_tb;

  localparam int NPLAYERS = 16;
  localparam int NTYPES = 16;
  localparam int NRECS = 5;
  localparam int NSLOTS = NPLAYERS * NTYPES;
  localparam longint CYCLE_LIMIT = 64'd20000000;

  typedef struct packed {
    logic [39:0] avg_frame_q8;
    logic [31:0] sec_mean;
    logic [31:0] total;
    logic [7:0]  type_out;
    logic        entry_valid;
    logic        ok;
  } meter_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [119:0] m_tdata;

  per_flow_byte_rate_meter_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state.
  logic [15:0] window_ms;
  logic [7:0]  p_type [NSLOTS];
  logic [31:0] p_total [NSLOTS];
  logic [31:0] p_second [NSLOTS];
  logic [31:0] p_frame [NSLOTS];
  logic [31:0] p_deadline [NSLOTS];
  logic        p_armed [NSLOTS];
  logic [31:0] p_sec_rec [NSLOTS][NRECS];
  int          p_sec_cnt [NSLOTS];
  logic [31:0] p_frm_rec [NSLOTS][NRECS];
  int          p_frm_cnt [NSLOTS];

  meter_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int ticks_sent = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit free_run = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  function automatic void clear_slot(int s);
    p_type[s] = '0;
    p_total[s] = '0;
    p_second[s] = '0;
    p_frame[s] = '0;
    p_deadline[s] = '0;
    p_armed[s] = 1'b0;
    p_sec_cnt[s] = 0;
    p_frm_cnt[s] = 0;
    for (int i = 0; i < NRECS; i++) begin
      p_sec_rec[s][i] = '0;
      p_frm_rec[s][i] = '0;
    end
  endfunction

  function automatic void push_second(int s, logic [31:0] v);
    if (p_sec_cnt[s] >= NRECS) begin
      for (int i = 0; i < NRECS - 1; i++) p_sec_rec[s][i] = p_sec_rec[s][i + 1];
      p_sec_rec[s][NRECS - 1] = v;
    end else begin
      p_sec_rec[s][p_sec_cnt[s]] = v;
      p_sec_cnt[s]++;
    end
  endfunction

  function automatic void push_frame(int s, logic [31:0] v);
    if (p_frm_cnt[s] >= NRECS) begin
      for (int i = 0; i < NRECS - 1; i++) p_frm_rec[s][i] = p_frm_rec[s][i + 1];
      p_frm_rec[s][NRECS - 1] = v;
    end else begin
      p_frm_rec[s][p_frm_cnt[s]] = v;
      p_frm_cnt[s]++;
    end
  endfunction

  function automatic meter_result_t predict_meter(logic [1:0] mode, logic [3:0] player,
                                                  logic [3:0] slot, logic [7:0] type_id,
                                                  logic [15:0] nbytes, logic [31:0] now);
    meter_result_t r;
    int s;
    int i;
    logic [63:0] sum;
    r = '0;
    if (mode == pfbrm_pkg::MODE_TICK) begin
      for (s = 0; s < NSLOTS; s++) begin
        if (p_type[s] != 0) begin
          if (!p_armed[s]) begin
            p_deadline[s] = now + 32'(window_ms);
            p_armed[s] = 1'b1;
          end else if (32'(now - p_deadline[s]) < 32'h80000000) begin
            push_second(s, p_second[s]);
            p_second[s] = '0;
            p_deadline[s] = now + 32'(window_ms);
          end
          push_frame(s, p_frame[s]);
          p_frame[s] = '0;
        end
      end
      r.ok = 1'b1;
    end else if (mode == pfbrm_pkg::MODE_ADD) begin
      if (type_id != 0) begin
        for (i = 0; i < NTYPES; i++) begin
          s = int'(player) * NTYPES + i;
          if (p_type[s] == 0 || p_type[s] == type_id) break;
        end
        if (i < NTYPES) begin
          s = int'(player) * NTYPES + i;
          p_type[s] = type_id;
          p_total[s] += 32'(nbytes);
          p_second[s] += 32'(nbytes);
          p_frame[s] += 32'(nbytes);
          r.ok = 1'b1;
        end
      end
    end else if (mode == pfbrm_pkg::MODE_RESET) begin
      for (i = 0; i < NTYPES; i++) clear_slot(int'(player) * NTYPES + i);
      r.ok = 1'b1;
    end else begin
      s = int'(player) * NTYPES + int'(slot);
      r.ok = 1'b1;
      r.entry_valid = p_type[s] != 0;
      r.type_out = p_type[s];
      r.total = p_total[s];
      if (p_sec_cnt[s] != 0) begin
        sum = '0;
        for (i = 0; i < p_sec_cnt[s]; i++) sum += 64'(p_sec_rec[s][i]);
        r.sec_mean = 32'(sum / 64'(p_sec_cnt[s]));
      end
      if (p_frm_cnt[s] != 0) begin
        sum = '0;
        for (i = 0; i < p_frm_cnt[s]; i++) sum += 64'(p_frm_rec[s][i]);
        r.avg_frame_q8 = 40'((sum << 8) / 64'(p_frm_cnt[s]));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  // Drops the valid for a random number of cycles; most gaps are short.
  task automatic random_gap();
    int n;
    if (free_run) return;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sends one operation and records its expected result at the accepting edge.
  task automatic send_op(logic [1:0] mode, logic [3:0] player, logic [3:0] slot,
                         logic [7:0] type_id, logic [15:0] nbytes, logic [31:0] now);
    if ($urandom_range(0, 2) == 0) random_gap();
    s_tdata <= {6'b0, now, nbytes, type_id, slot, player, mode};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_meter(mode, player, slot, type_id, nbytes, now));
    if (mode == pfbrm_pkg::MODE_QUERY) queries_sent++;
    if (mode == pfbrm_pkg::MODE_TICK) ticks_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_ms = v;
  endtask

  task automatic tick(logic [31:0] step);
    clock_ms += step;
    send_op(pfbrm_pkg::MODE_TICK, 4'($urandom), 4'($urandom), 8'($urandom),
            16'($urandom), clock_ms);
  endtask

  task automatic add(logic [3:0] p, logic [7:0] t, logic [15:0] b);
    send_op(pfbrm_pkg::MODE_ADD, p, 4'($urandom), t, b, $urandom);
  endtask

  task automatic query(logic [3:0] p, logic [3:0] sl);
    send_op(pfbrm_pkg::MODE_QUERY, p, sl, 8'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic test_directed();
    add(4'd0, 8'd0, 16'hFFFF);
    add(4'd0, 8'd255, 16'hFFFF);
    add(4'd0, 8'd1, 16'd0);
    add(4'd0, 8'd255, 16'd10);
    query(4'd0, 4'd0);
    query(4'd0, 4'd15);
    for (int i = 2; i <= 17; i++) add(4'd15, 8'(i), 16'(i));
    tick(32'd0);
    tick(32'd1000);
    query(4'd15, 4'd15);
    send_op(pfbrm_pkg::MODE_RESET, 4'd15, 4'd0, 8'd0, 16'd0, 32'hFFFFFFFF);
    query(4'd15, 4'd0);
    drain();
  endtask

  task automatic test_window_extremes();
    write_window(16'd0);
    add(4'd3, 8'd7, 16'd500);
    tick(32'd0);
    add(4'd3, 8'd7, 16'd300);
    tick(32'd0);
    query(4'd3, 4'd0);
    drain();
    write_window(16'hFFFF);
    // Run the clock close to wrapping so the deadline test sees the wrap.
    clock_ms = 32'hFFFF_FF00;
    add(4'd4, 8'd9, 16'd1);
    tick(32'd0);
    tick(32'hFFFF);
    tick(32'h100);
    query(4'd4, 4'd0);
    drain();
  endtask

  task automatic test_overflow();
    write_window(16'd1);
    for (int i = 0; i < 40; i++) begin
      add(4'd5, 8'd200, 16'hFFFF);
      if (i % 8 == 7) tick(32'd1);
    end
    query(4'd5, 4'd0);
    drain();
  endtask

  // Random traffic: mostly adds onto a few types, with random ticks, resets and queries.
  task automatic test_random(int count);
    int r;
    logic [3:0] p;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      p = 4'($urandom);
      if (r < 50) add(p, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)),
                      ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
      else if (r < 60) tick(32'($urandom_range(0, 1500)));
      else if (r < 63) send_op(pfbrm_pkg::MODE_RESET, p, 4'($urandom), 8'($urandom),
                               16'($urandom), $urandom);
      else if (r < 64) tick($urandom);
      else query(p, 4'($urandom));
      if (n % 350 == 349) begin
        drain();
        write_window(16'($urandom_range(1, 3000)));
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_window(pfbrm_pkg::WINDOW_RESET);
    hold_off = 1'b1;
    free_run = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) begin
        add(4'd6, 8'(i + 1), 16'(i * 100));
        query(4'd6, 4'(i));
      end
    join
    free_run = 1'b0;
    drain();
  endtask

  // Receiver: random stalls, a few of them long, with a long hold-off when asked.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        stall_left = $urandom_range(10, 40);
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= ~m_tready;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Checker.
  initial begin
    meter_result_t got;
    meter_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata[113:0];
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
          if (got.entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
          if (got.type_out !== want.type_out)
            report_mismatch("type_out", 64'(got.type_out), 64'(want.type_out));
          if (got.total !== want.total)
            report_mismatch("total_out", 64'(got.total), 64'(want.total));
          if (got.sec_mean !== want.sec_mean)
            report_mismatch("second mean", 64'(got.sec_mean), 64'(want.sec_mean));
          if (got.avg_frame_q8 !== want.avg_frame_q8)
            report_mismatch("avg_frame_q8", 64'(got.avg_frame_q8), 64'(want.avg_frame_q8));
        end
      end
    end
  end

  // Watchdog.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("per_flow_byte_rate_meter_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    window_ms = pfbrm_pkg::WINDOW_RESET;
    for (int s = 0; s < NSLOTS; s++) clear_slot(s);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_window_extremes();
    test_overflow();
    test_backpressure();
    test_random(1640);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0d results never arrived", expected_results.size());
    end
    $display("checked %0d results: %0d queries, %0d frame ticks, %0d mismatches",
             results_seen, queries_sent, ticks_sent, errors);
    if (errors == 0) $display("per_flow_byte_rate_meter_unit test passed");
    else $display("per_flow_byte_rate_meter_unit test failed");
    $finish;
  end

endmodule
